FILE: hw/rtl/tpa_pkg.sv
// Shared types and codes for the triangle primitive assembly block.
package tpa_pkg;

    // Field widths.
    localparam int INDEX_BITS = 24;
    localparam int COUNT_BITS = 16;

    // Opcodes of an input beat.
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_VERTEX = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    // Primitive kinds; the other codes are unknown kinds.
    localparam logic [2:0] KIND_LIST  = 3'd0;
    localparam logic [2:0] KIND_STRIP = 3'd1;
    localparam logic [2:0] KIND_FAN   = 3'd2;
    localparam logic [2:0] KIND_LOOP  = 3'd3;

    // Result kinds.
    localparam logic [1:0] RES_TRIANGLE    = 2'd0;
    localparam logic [1:0] RES_LOOP_VERTEX = 2'd1;
    localparam logic [1:0] RES_LOOP_CLOSED = 2'd2;

    // Progress codes within a list, strip or fan.
    localparam logic [COUNT_BITS-1:0] POS_FIRST  = COUNT_BITS'(0);
    localparam logic [COUNT_BITS-1:0] POS_SECOND = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] POS_EVEN   = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] POS_ODD    = COUNT_BITS'(3);

    typedef struct packed {
        logic [1:0]            opcode;
        logic [2:0]            prim_kind;
        logic [INDEX_BITS-1:0] vertex_index;
    } item_t;

    typedef struct packed {
        logic [1:0]            result_kind;
        logic [INDEX_BITS-1:0] corner_one;
        logic [INDEX_BITS-1:0] corner_two;
        logic [INDEX_BITS-1:0] corner_three;
        logic [COUNT_BITS-1:0] loop_length;
    } result_t;

endpackage

FILE: hw/rtl/triangle_primitive_assembly.sv
// Primitive assembly: turns list, strip, fan and line loop beats into results.
// An accepted beat is held in the input register and its result in the result register.
// One input beat per cycle while result_stall does not hold the output; the input register
// and the result register are the only stages, and each beat is handled in a single pass.
// Reset: rst_n clears all valid flags and the primitive state (list kind,
// zero indices, zero position); payload registers are not reset.
module triangle_primitive_assembly
    import tpa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Input stage.
    logic                  in_valid_reg;
    item_t                 in_reg;
    logic                  advance;

    // Primitive state.
    logic [2:0]            kind_reg,   kind_next;
    logic [INDEX_BITS-1:0] center_reg, center_next;
    logic [INDEX_BITS-1:0] older_reg,  older_next;
    logic [INDEX_BITS-1:0] newer_reg,  newer_next;
    logic [COUNT_BITS-1:0] pos_reg,    pos_next;

    // Result stage.
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;
    result_t               res;
    logic                  produce;

    logic [INDEX_BITS-1:0] tri_a, tri_b, tri_c;
    logic                  tri_fire;
    logic                  tri_ok;

    // The input beat moves on when the result register is free or being drained.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_reg <= item;
        end
    end

    // A triangle with any two equal corners is dropped.
    assign tri_ok = (tri_a != tri_b) && (tri_b != tri_c) && (tri_a != tri_c);

    // Next primitive state and the result of the beat in the input register.
    always_comb
    begin
        kind_next   = kind_reg;
        center_next = center_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        pos_next    = pos_reg;
        tri_a       = older_reg;
        tri_b       = newer_reg;
        tri_c       = in_reg.vertex_index;
        tri_fire    = 1'b0;
        produce     = 1'b0;
        res         = '0;

        case (in_reg.opcode)
            OP_BEGIN:
            begin
                kind_next   = in_reg.prim_kind;
                center_next = '0;
                older_next  = '0;
                newer_next  = '0;
                pos_next    = POS_FIRST;
            end
            OP_VERTEX:
            begin
                case (kind_reg)
                    KIND_LIST:
                    begin
                        if (pos_reg == POS_FIRST)
                        begin
                            older_next = in_reg.vertex_index;
                            pos_next   = POS_SECOND;
                        end
                        else if (pos_reg == POS_SECOND)
                        begin
                            newer_next = in_reg.vertex_index;
                            pos_next   = POS_EVEN;
                        end
                        else
                        begin
                            tri_fire = 1'b1;
                            pos_next = POS_FIRST;
                        end
                    end
                    KIND_STRIP:
                    begin
                        if (pos_reg == POS_FIRST)
                        begin
                            older_next = in_reg.vertex_index;
                            pos_next   = POS_SECOND;
                        end
                        else if (pos_reg == POS_SECOND)
                        begin
                            newer_next = in_reg.vertex_index;
                            pos_next   = POS_EVEN;
                        end
                        else
                        begin
                            // Odd triangles swap their first two corners.
                            if (pos_reg == POS_ODD)
                            begin
                                tri_a = newer_reg;
                                tri_b = older_reg;
                            end
                            tri_fire   = 1'b1;
                            older_next = newer_reg;
                            newer_next = in_reg.vertex_index;
                            pos_next   = (pos_reg == POS_ODD) ? POS_EVEN : POS_ODD;
                        end
                    end
                    KIND_FAN:
                    begin
                        if (pos_reg == POS_FIRST)
                        begin
                            center_next = in_reg.vertex_index;
                            pos_next    = POS_SECOND;
                        end
                        else if (pos_reg == POS_SECOND)
                        begin
                            newer_next = in_reg.vertex_index;
                            pos_next   = POS_EVEN;
                        end
                        else
                        begin
                            tri_a      = center_reg;
                            tri_fire   = 1'b1;
                            newer_next = in_reg.vertex_index;
                            pos_next   = POS_EVEN;
                        end
                    end
                    KIND_LOOP:
                    begin
                        produce         = 1'b1;
                        res.result_kind = RES_LOOP_VERTEX;
                        res.corner_one  = in_reg.vertex_index;
                        // The vertex count saturates at all ones.
                        if (pos_reg != '1)
                        begin
                            pos_next = pos_reg + COUNT_BITS'(1);
                        end
                    end
                    default:
                    begin
                        // Unknown kinds ignore vertices.
                    end
                endcase

                if (tri_fire && tri_ok)
                begin
                    produce          = 1'b1;
                    res.result_kind  = RES_TRIANGLE;
                    res.corner_one   = tri_a;
                    res.corner_two   = tri_b;
                    res.corner_three = tri_c;
                end
            end
            OP_END:
            begin
                if (kind_reg == KIND_LOOP)
                begin
                    produce         = 1'b1;
                    res.result_kind = RES_LOOP_CLOSED;
                    res.loop_length = pos_reg;
                end
                if (kind_reg <= KIND_LOOP)
                begin
                    pos_next = POS_FIRST;
                end
            end
            default:
            begin
                // The unused opcode is ignored.
            end
        endcase
    end

    // Primitive state registers update only when a beat is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_LIST;
            center_reg <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            pos_reg    <= '0;
        end
        else if (advance)
        begin
            kind_reg   <= kind_next;
            center_reg <= center_next;
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            pos_reg    <= pos_next;
        end
    end

    // Result register: loaded by a processed beat, cleared when taken.
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = produce;
        end
        else
        begin
            out_valid_next = out_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: dv/triangle_primitive_assembly_test.sv
// Self-checking testbench for the triangle primitive assembly block.
`timescale 1ns / 100ps

module triangle_primitive_assembly_test;
    import tpa_pkg::*;

    // Opcode that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Vertex beats of the line loop that is sent with no idle cycles between its beats.
    localparam int RUSH_VERTICES = 24;

    // Beats of the random part, after the directed beats.
    localparam int RANDOM_BEATS = 400;

    // Receiver hold-off that backs the block up into its input.
    localparam int HOLD_AFTER_BEATS = 120;
    localparam int HOLD_CYCLES      = 300;

    typedef struct {
        item_t beat;
        bit    rush;
    } pending_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Stimulus waiting to be offered, and results waiting to be seen.
    pending_t beats_to_send[$];
    result_t  results_due[$];

    int beats_queued = 0;
    int beats_taken = 0;
    int results_seen = 0;
    int fail_count = 0;
    bit rush_now = 1'b0;
    bit hold_on = 1'b0;

    // Assembly state as the predictor tracks it.
    logic [2:0]            pa_kind;
    logic [INDEX_BITS-1:0] fan_pivot;
    logic [INDEX_BITS-1:0] trail_index;
    logic [INDEX_BITS-1:0] lead_index;
    logic [COUNT_BITS-1:0] progress;

    triangle_primitive_assembly dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A triangle goes out only when its three corners are distinct.
    function automatic bit make_triangle(input logic [INDEX_BITS-1:0] a,
                                         input logic [INDEX_BITS-1:0] b,
                                         input logic [INDEX_BITS-1:0] c,
                                         inout result_t due);
        if (a == b || b == c || a == c)
            return 1'b0;
        due.result_kind  = RES_TRIANGLE;
        due.corner_one   = a;
        due.corner_two   = b;
        due.corner_three = c;
        return 1'b1;
    endfunction

    // Advances the assembly state by one beat; returns whether a result is due.
    function automatic bit assemble_beat(input item_t beat, output result_t due);
        logic [INDEX_BITS-1:0] v;
        bit                    made;
        v = beat.vertex_index;
        made = 1'b0;
        due = '0;
        case (beat.opcode)
            OP_BEGIN:
            begin
                pa_kind     = beat.prim_kind;
                fan_pivot   = '0;
                trail_index = '0;
                lead_index  = '0;
                progress    = POS_FIRST;
            end
            OP_VERTEX:
            begin
                case (pa_kind)
                    KIND_LIST:
                    begin
                        if (progress == POS_FIRST)
                        begin
                            trail_index = v;
                            progress = POS_SECOND;
                        end
                        else if (progress == POS_SECOND)
                        begin
                            lead_index = v;
                            progress = POS_EVEN;
                        end
                        else
                        begin
                            made = make_triangle(trail_index, lead_index, v, due);
                            progress = POS_FIRST;
                        end
                    end
                    KIND_STRIP:
                    begin
                        if (progress == POS_FIRST)
                        begin
                            trail_index = v;
                            progress = POS_SECOND;
                        end
                        else if (progress == POS_SECOND)
                        begin
                            lead_index = v;
                            progress = POS_EVEN;
                        end
                        else
                        begin
                            // Odd triangles swap the first two corners to keep winding.
                            if (progress == POS_ODD)
                                made = make_triangle(lead_index, trail_index, v, due);
                            else
                                made = make_triangle(trail_index, lead_index, v, due);
                            trail_index = lead_index;
                            lead_index = v;
                            progress = (progress == POS_ODD) ? POS_EVEN : POS_ODD;
                        end
                    end
                    KIND_FAN:
                    begin
                        if (progress == POS_FIRST)
                        begin
                            fan_pivot = v;
                            progress = POS_SECOND;
                        end
                        else if (progress == POS_SECOND)
                        begin
                            lead_index = v;
                            progress = POS_EVEN;
                        end
                        else
                        begin
                            made = make_triangle(fan_pivot, lead_index, v, due);
                            lead_index = v;
                        end
                    end
                    KIND_LOOP:
                    begin
                        due.result_kind = RES_LOOP_VERTEX;
                        due.corner_one = v;
                        made = 1'b1;
                        if (progress != '1)
                            progress = progress + COUNT_BITS'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_END:
            begin
                if (pa_kind == KIND_LOOP)
                begin
                    due.result_kind = RES_LOOP_CLOSED;
                    due.loop_length = progress;
                    made = 1'b1;
                end
                if (pa_kind <= KIND_LOOP)
                    progress = POS_FIRST;
            end
            default:
            begin
            end
        endcase
        return made;
    endfunction

    // Idle cycles before the next beat, with occasional runs of back-to-back beats.
    function automatic int idle_draw(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(8, 30);
        return $urandom_range(0, 16);
    endfunction

    // Vertex ids: a small pool makes repeated corners likely, the rest span the range.
    function automatic logic [INDEX_BITS-1:0] pick_index();
        case ($urandom_range(0, 3))
            0: return INDEX_BITS'($urandom_range(0, 3));
            1: return {INDEX_BITS{1'b1}} - INDEX_BITS'($urandom_range(0, 3));
            default: return INDEX_BITS'($urandom);
        endcase
    endfunction

    task automatic add_beat(input logic [1:0] op, input logic [2:0] kind,
                            input logic [INDEX_BITS-1:0] idx, input bit rush);
        pending_t p;
        p.beat.opcode = op;
        p.beat.prim_kind = kind;
        p.beat.vertex_index = idx;
        p.rush = rush;
        beats_to_send.insert(beats_to_send.size(), p);
        beats_queued++;
    endtask

    // Unused fields of each beat carry random values.
    task automatic add_begin(input logic [2:0] kind);
        add_beat(OP_BEGIN, kind, INDEX_BITS'($urandom), 1'b0);
    endtask

    task automatic add_index(input logic [INDEX_BITS-1:0] idx);
        add_beat(OP_VERTEX, 3'($urandom_range(0, 7)), idx, 1'b0);
    endtask

    task automatic add_end();
        add_beat(OP_END, 3'($urandom_range(0, 7)), INDEX_BITS'($urandom), 1'b0);
    endtask

    // Mostly well-formed primitives with random content, some noise in between.
    task automatic add_random_primitive();
        int pick;
        int count;
        pick = $urandom_range(0, 9);
        if (pick == 9)
        begin
            case ($urandom_range(0, 2))
                0: add_beat(OP_UNUSED, 3'($urandom_range(0, 7)), INDEX_BITS'($urandom), 1'b0);
                1: add_end();
                default: add_index(pick_index());
            endcase
        end
        else
        begin
            case (pick)
                0, 1: add_begin(KIND_LIST);
                2, 3: add_begin(KIND_STRIP);
                4, 5: add_begin(KIND_FAN);
                6, 7: add_begin(KIND_LOOP);
                default: add_begin(3'($urandom_range(4, 7)));
            endcase
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            for (int i = 0; i < count; i++)
                add_index(pick_index());
            if ($urandom_range(0, 7) != 0)
                add_end();
        end
    endtask

    // Input side: offers beats from the queue and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        static int      gap_left = 0;
        static int      tx_calm = 0;
        static result_t due;
        pending_t       next;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            rush_now <= 1'b0;
            gap_left = 0;
            pa_kind = KIND_LIST;
            fan_pivot = '0;
            trail_index = '0;
            lead_index = '0;
            progress = POS_FIRST;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                if (assemble_beat(item, due))
                    results_due.insert(results_due.size(), due);
                beats_taken <= beats_taken + 1;
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (beats_to_send.size() > 0)
                begin
                    next = beats_to_send.pop_front();
                    item <= next.beat;
                    item_valid <= 1'b1;
                    rush_now <= next.rush;
                    gap_left = next.rush ? 0 : idle_draw(tx_calm);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: stalls at random and checks each accepted result beat.
    always @(posedge clk or negedge rst_n)
    begin
        static int stall_left = 0;
        static int rx_calm = 0;
        result_t   want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen <= results_seen + 1;
                if (results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with nothing expected:", $realtime,
                                 " kind %0d corners %h %h %h length %0d",
                                 result.result_kind, result.corner_one,
                                 result.corner_two, result.corner_three, result.loop_length);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (result.result_kind !== want.result_kind ||
                        result.corner_one !== want.corner_one ||
                        result.corner_two !== want.corner_two ||
                        result.corner_three !== want.corner_three ||
                        result.loop_length !== want.loop_length)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: expected kind %0d corners %h %h %h length %0d",
                                     $realtime, want.result_kind, want.corner_one,
                                     want.corner_two, want.corner_three, want.loop_length);
                            $display("%0t: actual   kind %0d corners %h %h %h length %0d",
                                     $realtime, result.result_kind, result.corner_one,
                                     result.corner_two, result.corner_three, result.loop_length);
                        end
                    end
                end
                stall_left = rush_now ? 0 : idle_draw(rx_calm);
            end
            result_stall <= hold_on || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // One long receiver hold-off once traffic is under way.
    always @(posedge clk or negedge rst_n)
    begin
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_left = 0;
        end
        else if (!hold_done && beats_taken >= HOLD_AFTER_BEATS)
        begin
            hold_on <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_on <= 1'b0;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int directed_beats;

        // Vertices before any begin form a list.
        add_index('0);
        add_index('1);
        add_index(INDEX_BITS'(1));

        // Strip with swapped odd triangles and a repeated corner whose dropped triangle still counts.
        add_begin(KIND_STRIP);
        add_index(INDEX_BITS'(1));
        add_index(INDEX_BITS'(2));
        add_index(INDEX_BITS'(3));
        add_index(INDEX_BITS'(4));
        add_index(INDEX_BITS'(3));
        add_index(INDEX_BITS'(5));
        add_end();

        // Fan around its first vertex.
        add_begin(KIND_FAN);
        add_index(INDEX_BITS'(9));
        add_index(INDEX_BITS'(10));
        add_index(INDEX_BITS'(11));
        add_end();

        // List with a repeated corner, then a partial triangle left at the end.
        add_begin(KIND_LIST);
        add_index(INDEX_BITS'(5));
        add_index(INDEX_BITS'(5));
        add_index(INDEX_BITS'(7));
        add_index(INDEX_BITS'(8));
        add_end();

        // Empty loop, then a loop that restarts after its end without a begin.
        add_begin(KIND_LOOP);
        add_end();
        add_index('1);
        add_end();

        // Unknown kind and the unused opcode.
        add_begin(3'd7);
        add_index(INDEX_BITS'(6));
        add_end();
        add_beat(OP_UNUSED, 3'd5, '1, 1'b0);
        directed_beats = beats_queued;

        while (beats_queued < directed_beats + RANDOM_BEATS)
            add_random_primitive();

        // A line loop sent back to back with no idle cycles between its beats.
        add_beat(OP_BEGIN, KIND_LOOP, '0, 1'b1);
        for (int i = 0; i < RUSH_VERTICES; i++)
            add_beat(OP_VERTEX, 3'($urandom_range(0, 7)), INDEX_BITS'($urandom), 1'b1);
        add_beat(OP_END, KIND_LOOP, '0, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken != beats_queued)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run sent %0d input beats and checked %0d result beats with %0d failures.",
                 beats_taken, results_seen, fail_count);
        $display("It covered lists, strips, fans, loops, unknown kinds and a back-to-back loop.");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4000000;
        $display("Timed out with %0d results still expected.", results_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: triangle_primitive_assembly.f
hw/rtl/tpa_pkg.sv
hw/rtl/triangle_primitive_assembly.sv
dv/triangle_primitive_assembly_test.sv
